### design/imuocs_pkg.sv
// ----------------------------------------------------------------------------
// IMU offset calibration package
// Shared widths, operation codes, status codes and sequencer states for the
// IMU offset calibration and scaling block.
// ----------------------------------------------------------------------------
package imuocs_pkg;

  // Field and storage widths fixed by the sensor format.
  localparam int RAW_W      = 16;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 33;
  localparam int ACC_OUT_W  = 17;
  localparam int GYR_OUT_W  = 14;
  localparam int TEMP_RAW_W = 11;
  localparam int TEMP_W     = 12;

  // Six axes share one register file: accel X/Y/Z first, then gyro X/Y/Z.
  localparam int NAXES = 6;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] IDX_ACCEL_BASE = 3'd0;
  localparam logic [IDX_W-1:0] IDX_ACCEL_Z    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_GYRO_BASE  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_LAST       = 3'd5;

  // Scale factors: accel times 3/4, gyro times 125/1024, after the offset
  // fraction bits are dropped.
  localparam logic signed [7:0] ACC_GAIN = 8'sd3;
  localparam logic signed [7:0] GYR_GAIN = 8'sd125;
  localparam int ACC_SHIFT_EXTRA = 2;
  localparam int GYR_SHIFT_EXTRA = 10;

  // Register reset value and temperature bias in eighths of a degree.
  localparam logic [CNT_W-1:0]         SAMPLE_COUNT_RST = 16'd100;
  localparam logic signed [TEMP_W-1:0] TEMP_BIAS        = 12'sd184;

  // Operation codes of the input transaction.
  localparam logic [1:0] OP_CONVERT   = 2'd0;
  localparam logic [1:0] OP_GYRO_CAL  = 2'd1;
  localparam logic [1:0] OP_ACCEL_CAL = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CONVERTED  = 2'd0,
    ST_ACCUM      = 2'd1,
    ST_CAL_DONE   = 2'd2,
    ST_ZERO_COUNT = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV_MUL,
    S_CONV_SAT,
    S_ACC,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_STORE,
    S_WRITE
  } fsm_state_t;

endpackage

### design/imu_offset_calibrate_and_scale_top.sv
// ----------------------------------------------------------------------------
// IMU offset calibration and scaling
// Removes stored zero offsets from raw IMU samples and scales them to fixed
// units, or accumulates calibration samples and averages them into offsets.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one raw sample and an
//   opcode; the result channel (out_valid / out_ready) returns one result per
//   transaction. cfg_wr_en / cfg_wr_data write the sample count per
//   calibration; write it only while the block is idle.
//   Processing: a convert transaction passes each axis in turn through
//   the shared multiply and saturate unit, a multiply step and then a
//   saturate step, then loads the output. A calibration sample adds each
//   axis in turn on the shared adder, then loads the output; the final
//   sample also runs a restoring divider, one quotient bit per cycle, on
//   each axis in turn before the load. One transaction is processed at a
//   time; in_ready is high only while the sequencer is idle, so a new
//   transaction is accepted only after the last result is loaded. The
//   output register holds a result until it is taken, and the next
//   transaction can be accepted meanwhile; it then waits in its last step
//   while the receiver stalls.
//   Reset (rst_n low, synchronous) clears offsets, sums and counters and
//   sets the sample count to 100.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_and_scale_top
  import imuocs_pkg::*;
#(
  parameter int OFFSET_FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port
  input  logic                        cfg_wr_en,
  input  logic [CNT_W-1:0]            cfg_wr_data,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic signed [RAW_W-1:0]     in_accel_x,
  input  logic signed [RAW_W-1:0]     in_accel_y,
  input  logic signed [RAW_W-1:0]     in_accel_z,
  input  logic signed [RAW_W-1:0]     in_gyro_x,
  input  logic signed [RAW_W-1:0]     in_gyro_y,
  input  logic signed [RAW_W-1:0]     in_gyro_z,
  input  logic [7:0]                  in_temp_msb,
  input  logic [7:0]                  in_temp_lsb,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ACC_OUT_W-1:0] out_accel_x_out,
  output logic signed [ACC_OUT_W-1:0] out_accel_y_out,
  output logic signed [ACC_OUT_W-1:0] out_accel_z_out,
  output logic signed [GYR_OUT_W-1:0] out_gyro_x_out,
  output logic signed [GYR_OUT_W-1:0] out_gyro_y_out,
  output logic signed [GYR_OUT_W-1:0] out_gyro_z_out,
  output logic signed [TEMP_W-1:0]    out_temp_out,
  output logic [1:0]                  out_status
);

  // Derived widths. An offset can exceed the raw range when the sample count
  // was lowered during a calibration, so it keeps the full quotient width.
  localparam int F      = OFFSET_FRACTION_BITS;
  localparam int OFF_W  = SUM_W + F;
  localparam int DIFF_W = OFF_W + 1;
  localparam int PROD_W = DIFF_W + 8;
  localparam int DVD_W  = SUM_W + F;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // One g in raw counts with fraction bits, rounded.
  localparam logic signed [OFF_W-1:0] ONE_G =
    OFF_W'((((64'sd16384) <<< F) * 2 + 3) / 6);

  // Saturation bounds at the product width.
  localparam logic signed [PROD_W-1:0] ACC_MAX = PROD_W'((64'sd1 <<< (ACC_OUT_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] ACC_MIN = PROD_W'(-(64'sd1 <<< (ACC_OUT_W - 1)));
  localparam logic signed [PROD_W-1:0] GYR_MAX = PROD_W'((64'sd1 <<< (GYR_OUT_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] GYR_MIN = PROD_W'(-(64'sd1 <<< (GYR_OUT_W - 1)));

  // Sequencer and architectural state.
  fsm_state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]            sample_count_r;
  logic signed [OFF_W-1:0]     off_r [NAXES];
  logic signed [SUM_W-1:0]     sum_r [NAXES];
  logic [CNT_W-1:0]            accel_cnt_r;
  logic [CNT_W-1:0]            gyro_cnt_r;
  logic                        out_valid_r;

  // Working registers of the current transaction.
  logic signed [RAW_W-1:0]     raw_r [NAXES];
  logic                        conv_r;
  logic                        grp_r;
  logic [CNT_W-1:0]            divisor_r;
  logic [IDX_W-1:0]            idx_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [DVD_W-1:0]            dvd_r;
  logic [CNT_W-1:0]            rem_r;
  logic [STEP_W-1:0]           step_r;
  logic                        neg_r;
  logic signed [ACC_OUT_W-1:0] res_acc_r [3];
  logic signed [GYR_OUT_W-1:0] res_gyr_r [3];
  logic signed [TEMP_W-1:0]    res_temp_r;
  status_t                     res_status_r;

  // Output registers.
  logic signed [ACC_OUT_W-1:0] out_acc_r [3];
  logic signed [GYR_OUT_W-1:0] out_gyr_r [3];
  logic signed [TEMP_W-1:0]    out_temp_r;
  status_t                     out_status_r;

  // Control decode.
  logic                        accept;
  logic                        out_load;
  logic                        in_is_cal;
  logic [IDX_W-1:0]            base_idx;
  logic                        last_axis;
  logic [CNT_W-1:0]            cnt_cur;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        zero_cnt;
  logic                        cal_final;

  // Shared datapath signals.
  logic signed [RAW_W-1:0]     raw_sel;
  logic signed [OFF_W-1:0]     off_sel;
  logic signed [SUM_W-1:0]     sum_sel;
  logic                        is_acc_axis;
  logic [1:0]                  acc_lane;
  logic [1:0]                  gyr_lane;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    shifted;
  logic signed [ACC_OUT_W-1:0] acc_val;
  logic signed [GYR_OUT_W-1:0] gyr_val;
  logic [SUM_W-1:0]            sum_mag;
  logic [CNT_W:0]              trial;
  logic                        fits;
  logic [CNT_W-1:0]            rem_nxt;
  logic signed [OFF_W-1:0]     q_mag;
  logic signed [OFF_W-1:0]     off_q;
  logic signed [TEMP_RAW_W-1:0] temp_code;

  // Transaction and group decode.
  assign in_is_cal = (in_opcode == OP_GYRO_CAL) || (in_opcode == OP_ACCEL_CAL);
  assign base_idx  = grp_r ? IDX_GYRO_BASE : IDX_ACCEL_BASE;
  assign last_axis = (idx_r == IDX_W'(base_idx + 3'd2));
  assign cnt_cur   = grp_r ? gyro_cnt_r : accel_cnt_r;
  assign cnt_inc   = CNT_W'(cnt_cur + 1'b1);
  assign zero_cnt  = (divisor_r == '0);
  assign cal_final = (cnt_inc >= divisor_r);

  // Register file reads at the current axis index.
  assign raw_sel     = raw_r[idx_r];
  assign off_sel     = off_r[idx_r];
  assign sum_sel     = sum_r[idx_r];
  assign is_acc_axis = (idx_r < IDX_GYRO_BASE);
  assign acc_lane    = idx_r[1:0];
  assign gyr_lane    = 2'(idx_r - IDX_GYRO_BASE);

  // Conversion unit: offset subtract and constant multiply, then shift and
  // saturate from the registered product.
  assign diff = (DIFF_W'(raw_sel) <<< F) - DIFF_W'(off_sel);
  assign prod = PROD_W'(diff) * PROD_W'(is_acc_axis ? ACC_GAIN : GYR_GAIN);

  always_comb begin
    if (is_acc_axis) begin
      shifted = prod_r >>> (F + ACC_SHIFT_EXTRA);
    end else begin
      shifted = prod_r >>> (F + GYR_SHIFT_EXTRA);
    end
    if (shifted > ACC_MAX) begin
      acc_val = ACC_MAX[ACC_OUT_W-1:0];
    end else if (shifted < ACC_MIN) begin
      acc_val = ACC_MIN[ACC_OUT_W-1:0];
    end else begin
      acc_val = shifted[ACC_OUT_W-1:0];
    end
    if (shifted > GYR_MAX) begin
      gyr_val = GYR_MAX[GYR_OUT_W-1:0];
    end else if (shifted < GYR_MIN) begin
      gyr_val = GYR_MIN[GYR_OUT_W-1:0];
    end else begin
      gyr_val = shifted[GYR_OUT_W-1:0];
    end
  end

  // Restoring divider: one quotient bit per step; the quotient shifts into
  // the dividend register as the dividend bits shift out.
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign fits    = (trial >= {1'b0, divisor_r});
  assign rem_nxt = fits ? CNT_W'(trial - {1'b0, divisor_r}) : CNT_W'(trial);
  assign q_mag   = dvd_r[OFF_W-1:0];

  // Signed mean offset; the accel Z offset also has one g removed.
  always_comb begin
    off_q = neg_r ? -q_mag : q_mag;
    if (!grp_r && (idx_r == IDX_ACCEL_Z)) begin
      off_q = off_q - ONE_G;
    end
  end

  // Temperature decode: eleven-bit two's complement value plus bias.
  assign temp_code = {in_temp_msb, in_temp_lsb[7:5]};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_is_cal ? S_ACC : S_CONV_MUL;
        end
      end
      S_CONV_MUL: begin
        state_nxt = S_CONV_SAT;
      end
      S_CONV_SAT: begin
        state_nxt = (idx_r == IDX_LAST) ? S_WRITE : S_CONV_MUL;
      end
      S_ACC: begin
        if (last_axis) begin
          state_nxt = (!zero_cnt && cal_final) ? S_DIV_INIT : S_WRITE;
        end
      end
      S_DIV_INIT: begin
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        state_nxt = last_axis ? S_WRITE : S_DIV_INIT;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_WRITE: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Sequencer, configuration, offsets, sums and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= SAMPLE_COUNT_RST;
      accel_cnt_r    <= '0;
      gyro_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NAXES; i++) begin
        off_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        sample_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Accumulate one axis per cycle, or clear on a zero sample count.
      if (state_r == S_ACC) begin
        sum_r[idx_r] <= zero_cnt ? '0 : SUM_W'(sum_sel + SUM_W'(raw_sel));
        if (last_axis) begin
          if (zero_cnt || cal_final) begin
            if (grp_r) begin
              gyro_cnt_r <= '0;
            end else begin
              accel_cnt_r <= '0;
            end
          end else if (grp_r) begin
            gyro_cnt_r <= cnt_inc;
          end else begin
            accel_cnt_r <= cnt_inc;
          end
        end
      end
      // Store one mean offset and clear its sum.
      if (state_r == S_DIV_STORE) begin
        off_r[idx_r] <= off_q;
        sum_r[idx_r] <= '0;
      end
    end
  end

  // Working registers of the shared units.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r[0]  <= in_accel_x;
      raw_r[1]  <= in_accel_y;
      raw_r[2]  <= in_accel_z;
      raw_r[3]  <= in_gyro_x;
      raw_r[4]  <= in_gyro_y;
      raw_r[5]  <= in_gyro_z;
      conv_r    <= !in_is_cal;
      grp_r     <= (in_opcode == OP_GYRO_CAL);
      divisor_r <= sample_count_r;
      if (in_opcode == OP_GYRO_CAL) begin
        idx_r <= IDX_GYRO_BASE;
      end else begin
        idx_r <= IDX_ACCEL_BASE;
      end
      for (int i = 0; i < 3; i++) begin
        res_acc_r[i] <= '0;
        res_gyr_r[i] <= '0;
      end
      res_temp_r   <= in_is_cal ? '0 : TEMP_W'(TEMP_W'(temp_code) + TEMP_BIAS);
      res_status_r <= ST_CONVERTED;
    end
    unique case (state_r)
      S_CONV_MUL: begin
        prod_r <= prod;
      end
      S_CONV_SAT: begin
        if (is_acc_axis) begin
          res_acc_r[acc_lane] <= acc_val;
        end else begin
          res_gyr_r[gyr_lane] <= gyr_val;
        end
        idx_r <= IDX_W'(idx_r + 1'b1);
      end
      S_ACC: begin
        if (last_axis) begin
          idx_r <= base_idx;
          if (zero_cnt) begin
            res_status_r <= ST_ZERO_COUNT;
          end else if (cal_final) begin
            res_status_r <= ST_CAL_DONE;
          end else begin
            res_status_r <= ST_ACCUM;
          end
        end else begin
          idx_r <= IDX_W'(idx_r + 1'b1);
        end
      end
      S_DIV_INIT: begin
        dvd_r  <= DVD_W'(sum_mag) << F;
        neg_r  <= sum_sel[SUM_W-1];
        rem_r  <= '0;
        step_r <= '0;
      end
      S_DIV_STEP: begin
        dvd_r  <= {dvd_r[DVD_W-2:0], fits};
        rem_r  <= rem_nxt;
        step_r <= STEP_W'(step_r + 1'b1);
      end
      S_DIV_STORE: begin
        idx_r <= IDX_W'(idx_r + 1'b1);
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded when the receiver side is free.
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_acc_r[i] <= res_acc_r[i];
        out_gyr_r[i] <= res_gyr_r[i];
      end
      out_temp_r   <= res_temp_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accel_x_out = out_acc_r[0];
  assign out_accel_y_out = out_acc_r[1];
  assign out_accel_z_out = out_acc_r[2];
  assign out_gyro_x_out  = out_gyr_r[0];
  assign out_gyro_y_out  = out_gyr_r[1];
  assign out_gyro_z_out  = out_gyr_r[2];
  assign out_temp_out    = out_temp_r;
  assign out_status      = out_status_r;

  // The divider only runs on a nonzero divisor and keeps its remainder below it.
  a_div_remainder : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP) |-> ((divisor_r != '0) && (rem_r < divisor_r)))
    else $error("divider remainder not below divisor");

  // A zero sample count leaves the counter of that calibration cleared.
  a_zero_count_clears : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WRITE) && (res_status_r == ST_ZERO_COUNT)) |->
      (cnt_cur == '0))
    else $error("counter not cleared after zero sample count");

  // Converted status goes with convert transactions only.
  a_status_matches_op : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> ((res_status_r == ST_CONVERTED) == conv_r))
    else $error("result status does not match transaction type");

endmodule
